>>> hdl/fatan_pkg.sv
// Package with the fixed-point formats and coefficients of the fast arctangent.
package fatan_pkg;

  localparam int unsigned InWidth  = 24;
  localparam int unsigned OutWidth = 18;
  localparam int unsigned FracBits = 16;
  localparam int unsigned QuoBits  = 20;
  localparam int unsigned RemWidth = 64;

  typedef logic signed [InWidth-1:0]  sample_t;
  typedef logic signed [OutWidth-1:0] angle_t;
  typedef logic signed [17:0]         coef_t;

  // Coefficients in Q16, small row (|x| < 1) then large row (|x| >= 1).
  localparam coef_t SmC0   = 18'sd65536;
  localparam coef_t SmC1   = 18'sd28284;
  localparam coef_t SmC2   = 18'sd65536;
  localparam coef_t SmC3   = 18'sd3822;
  localparam coef_t LgC0   = -18'sd28285;
  localparam coef_t LgC1   = -18'sd65536;
  localparam coef_t LgC2   = 18'sd3822;
  localparam coef_t LgC3   = 18'sd65536;
  localparam coef_t BothC4 = 18'sd50098;
  localparam coef_t HalfPi = 18'sd102944;

  localparam logic signed [23:0] AngleMax = 24'sd131071;
  localparam logic signed [23:0] AngleMin = -24'sd131072;

endpackage

>>> hdl/fast_arctangent.sv
// Fast arctangent: pipelined rational approximation with a radix-2 divider.
//
//  channel   dir  fields (low bit up)        handshake
//  s_axis    in   tdata[23:0] sample_in      tvalid / tready
//  m_axis    out  tdata[17:0] angle_out      tvalid / tready
//
// One word enters per cycle while the pipeline is not held by a stall.
// Six arithmetic stages form the numerator and denominator, twenty stages
// each resolve one quotient bit, and one stage applies the signs, adds the
// bias and saturates. All stages advance together; when the output word
// is not taken the whole pipeline holds. Reset clears only the valid bits.
module fast_arctangent (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [23:0]           s_axis_tdata_i,   // [23:0] sample_in
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [23:0]           m_axis_tdata_o    // [17:0] angle_out, rest zero
);
  import fatan_pkg::*;

  function automatic logic signed [32:0] rnd16(input logic signed [48:0] v);
    logic signed [48:0] t;
    t = v[48] ? -v : v;
    t = (t + 49'sd32768) >>> FracBits;
    return v[48] ? -t[32:0] : t[32:0];
  endfunction

  logic en;
  assign en = ~m_axis_tvalid_o | m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Stage 1: magnitude and row.
  logic        v1_q;
  logic        neg1_q, row1_q;
  logic [23:0] a1_q;
  // Stage 2: square.
  logic        v2_q, neg2_q, row2_q;
  logic [23:0] a2_q;
  logic [30:0] x2_2_q;
  // Stage 3: coefficient products.
  logic        v3_q, neg3_q, row3_q;
  logic [23:0] a3_q;
  logic [30:0] x2_3_q;
  logic signed [48:0] p1_q, p4_q;
  // Stage 4: inner terms.
  logic        v4_q, neg4_q, row4_q;
  logic [23:0] a4_q;
  logic [30:0] x2_4_q;
  logic signed [33:0] n1_q, d1_q;
  // Stage 5: numerator and outer denominator product.
  logic        v5_q, neg5_q, row5_q;
  logic signed [58:0] num_q;
  logic signed [65:0] dd_q;
  // Stage 6: divider operands.
  logic        v6_q, neg6_q, row6_q, nneg6_q;
  logic [RemWidth-1:0] rem6_q;
  logic [44:0]         den6_q;

  logic [23:0] a_d;
  logic [47:0] sq;
  logic [48:0] sq_rnd;
  logic signed [31:0] x2s_3;
  logic signed [33:0] n1_d, d1_d;
  logic signed [31:0] x2s_4;
  logic [57:0] mag_d;
  logic [49:0] den_r;
  logic [44:0] den_d;

  always_comb begin
    a_d = s_axis_tdata_i[23] ? 24'(-s_axis_tdata_i) : s_axis_tdata_i;
    sq = 48'(a1_q) * 48'(a1_q);
    sq_rnd = {1'b0, sq} + 49'd32768;
    x2s_3 = {1'b0, x2_2_q};
    n1_d = 34'(rnd16(p1_q)) + 34'(row3_q ? LgC0 : SmC0);
    d1_d = 34'(rnd16(p4_q)) + 34'(row3_q ? LgC3 : SmC3);
    x2s_4 = {1'b0, x2_4_q};
    mag_d = num_q[58] ? 58'(-num_q) : num_q[57:0];
    den_r = 50'((dd_q + 66'sd32768) >>> FracBits) + 50'(row5_q ? LgC2 : SmC2);
    den_d = (den_r == '0) ? 45'd1 : den_r[44:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg1_q <= s_axis_tdata_i[23];
      a1_q   <= a_d;
      row1_q <= (a_d >= 24'd65536);

      neg2_q <= neg1_q; row2_q <= row1_q; a2_q <= a1_q;
      x2_2_q <= sq_rnd[46:16];

      neg3_q <= neg2_q; row3_q <= row2_q; a3_q <= a2_q; x2_3_q <= x2_2_q;
      p1_q   <= 49'(x2s_3) * 49'(row2_q ? LgC1 : SmC1);
      p4_q   <= 49'(x2s_3) * 49'(BothC4);

      neg4_q <= neg3_q; row4_q <= row3_q; a4_q <= a3_q; x2_4_q <= x2_3_q;
      n1_q   <= n1_d;
      d1_q   <= d1_d;

      neg5_q <= neg4_q; row5_q <= row4_q;
      num_q  <= 59'(n1_q) * 59'(signed'({1'b0, a4_q}));
      dd_q   <= 66'(66'(d1_q) * 66'(x2s_4));

      neg6_q  <= neg5_q; row6_q <= row5_q; nneg6_q <= num_q[58];
      den6_q  <= den_d;
      rem6_q  <= RemWidth'(mag_d) + RemWidth'(den_d[44:1]);
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  logic                v_q    [QuoBits+1];
  logic                neg_q  [QuoBits+1];
  logic                row_q  [QuoBits+1];
  logic                nneg_q [QuoBits+1];
  logic [RemWidth-1:0] rem_q  [QuoBits+1];
  logic [44:0]         den_q  [QuoBits+1];
  logic [QuoBits-1:0]  quo_q  [QuoBits+1];

  always_comb begin
    v_q[0] = v6_q; neg_q[0] = neg6_q; row_q[0] = row6_q; nneg_q[0] = nneg6_q;
    rem_q[0] = rem6_q; den_q[0] = den6_q; quo_q[0] = '0;
  end

  for (genvar k = 0; k < QuoBits; k++) begin : g_div
    logic [RemWidth-1:0] trial;
    logic                take;
    assign trial = RemWidth'(den_q[k]) << (QuoBits - 1 - k);
    assign take  = (rem_q[k] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        neg_q[k+1]  <= neg_q[k];
        row_q[k+1]  <= row_q[k];
        nneg_q[k+1] <= nneg_q[k];
        den_q[k+1]  <= den_q[k];
        rem_q[k+1]  <= take ? rem_q[k] - trial : rem_q[k];
        quo_q[k+1]  <= {quo_q[k][QuoBits-2:0], take};
      end
    end
  end

  // Output stage: sign, bias, sign of x, saturation.
  logic signed [23:0] qs, r0, r1;
  logic [17:0]        angle_d;
  logic               out_v_q;
  angle_t             angle_q;

  always_comb begin
    qs = signed'({4'b0, quo_q[QuoBits]});
    if (nneg_q[QuoBits]) qs = -qs;
    r0 = qs + (row_q[QuoBits] ? 24'(HalfPi) : 24'sd0);
    r1 = neg_q[QuoBits] ? -r0 : r0;
    if (r1 > AngleMax) angle_d = AngleMax[17:0];
    else if (r1 < AngleMin) angle_d = AngleMin[17:0];
    else angle_d = r1[17:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v_q[QuoBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) angle_q <= angle_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {6'b0, angle_q};

  // A word that is not taken stays until it is.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  // A stall freezes the whole pipeline.
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |=> $stable(v6_q) && $stable(v_q[QuoBits]))
    else $error("pipeline moved during a stall");

  // The final remainder is always below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QuoBits] |-> rem_q[QuoBits] < RemWidth'(den_q[QuoBits]))
    else $error("divider remainder out of range");

endmodule

>>> tb/sv/tb_fast_arctangent.sv
// Testbench for the fast arctangent: random and directed samples checked against a predictor.
`timescale 1ns / 1ps

module tb_fast_arctangent;
  import fatan_pkg::*;

  // Expected angles in order of acceptance, checked as output words arrive.
  class angle_scoreboard;
    angle_t pending_angles[$];
    int     mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function longint round_shift(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -(((-v) + half) >>> s);
    endfunction

    static function angle_t predict_angle(sample_t x);
      longint mag, x2, n1, num, d1, den, q, r;
      longint c0, c1, c2, c3, bias;
      bit     neg;
      neg = x[InWidth-1];
      mag = neg ? -longint'(x) : longint'(x);
      if (mag >= (longint'(1) << FracBits)) begin
        c0 = LgC0; c1 = LgC1; c2 = LgC2; c3 = LgC3; bias = HalfPi;
      end else begin
        c0 = SmC0; c1 = SmC1; c2 = SmC2; c3 = SmC3; bias = 0;
      end
      x2 = (mag * mag + (longint'(1) << (FracBits - 1))) >>> FracBits;
      n1 = round_shift(c1 * x2, 16) + c0;
      num = n1 * mag;
      d1 = round_shift(longint'(BothC4) * x2, 16) + c3;
      den = round_shift(d1 * x2, FracBits) + c2;
      if (den <= 0) den = 1;
      q = ((num < 0 ? -num : num) + den / 2) / den;
      if (num < 0) q = -q;
      r = q + bias;
      if (neg) r = -r;
      if (r > AngleMax) r = AngleMax;
      if (r < AngleMin) r = AngleMin;
      return angle_t'(r);
    endfunction

    function void note_sample(sample_t x);
      pending_angles.push_back(predict_angle(x));
    endfunction

    function void check_angle(logic [23:0] word);
      angle_t exp_angle;
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", word));
        return;
      end
      exp_angle = pending_angles.pop_front();
      if (word[OutWidth-1:0] !== exp_angle || word[23:OutWidth] !== '0)
        report_mismatch($sformatf("angle %h, expected %h", word, exp_angle));
    endfunction

    function void report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  angle_scoreboard sb = new();
  bit calm_phase = 1'b0;
  bit stim_done = 1'b0;

  sample_t directed[$] = '{24'sh000000, 24'sh000001, -24'sh000001, 24'sh00FFFF,
    24'sh010000, -24'sh010000, -24'sh00FFFF, 24'sh010001, 24'sh008000,
    24'sh020000, -24'sh020000, 24'sh7FFFFF, -24'sh7FFFFF, 24'sh800000,
    24'sh100000, -24'sh100000, 24'sh555555, -24'sh555555, 24'sh000100,
    24'sh00C000, -24'sh018000};

  fast_arctangent dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Leaves tvalid high on return so that words can follow back to back.
  task automatic send_sample(sample_t x);
    while (!calm_phase && $urandom_range(99) < 35) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= x;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_sample(x);
    @(negedge clk_i);
  endtask

  // Magnitudes up to three or small ones in most draws, with the full range and single bits mixed in.
  function automatic sample_t random_sample();
    int unsigned pick;
    sample_t x;
    pick = $urandom_range(99);
    if (pick < 40)      x = sample_t'($urandom_range(196608));
    else if (pick < 55) x = sample_t'($urandom_range(4096));
    else if (pick < 65) x = sample_t'(1 << $urandom_range(23));
    else                x = sample_t'($urandom);
    if ($urandom_range(1)) x = -x;
    return x;
  endfunction

  initial begin
    @(posedge rst_ni);
    foreach (directed[i]) send_sample(directed[i]);
    for (int i = 0; i < 550; i++) begin
      calm_phase = (i >= 150 && i < 230);
      send_sample(random_sample());
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: a long hold-off early on so the pipeline fills and stalls the input.
  initial begin
    @(posedge rst_ni);
    repeat (60) @(negedge clk_i);
    m_axis_tready_i <= 1'b0;
    repeat (80) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= calm_phase || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_angle(m_axis_tdata_o);
  end

  initial begin
    wait (stim_done);
    while (sb.pending_angles.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
